// File: sv/earliest_free_unit_layer_dispatch_defines.svh
// Assertion macros used by the checker of the layer dispatch block.
`ifndef EARLIEST_FREE_UNIT_LAYER_DISPATCH_DEFINES_SVH
`define EARLIEST_FREE_UNIT_LAYER_DISPATCH_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define EFULD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The antecedent implies the consequent in the following cycle.
`define EFULD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/efuld_pkg.sv
// Package with the widths, constants and shared types of the layer dispatch block.
package efuld_pkg;

    localparam int MAX_UNITS_DEF = 8;
    localparam int FIELD_W = 16;
    localparam int TIME_W = 32;
    localparam int CFG_W = 4;
    localparam int UNIT_OUT_W = 3;
    localparam logic [CFG_W-1:0] UNITS_RESET = 4'd8;

    typedef struct packed {
        logic              lt;
        logic [TIME_W-1:0] sum;
    } alu_res_t;

endpackage

// File: sv/efuld_if.sv
// Interfaces for the layer request, result and configuration channels.
interface efuld_layer_if import efuld_pkg::*;;
    logic               valid;
    logic               ready;
    logic [FIELD_W-1:0] host_time;
    logic [FIELD_W-1:0] transfer_time;
    logic [FIELD_W-1:0] unit_time;
    logic               last_layer;

    modport source (output valid, host_time, transfer_time, unit_time, last_layer,
                    input ready);
    modport sink (input valid, host_time, transfer_time, unit_time, last_layer,
                  output ready);
endinterface

interface efuld_result_if import efuld_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [UNIT_OUT_W-1:0] unit_index;
    logic [TIME_W-1:0]     start_time;
    logic [TIME_W-1:0]     finish_time;
    logic [TIME_W-1:0]     makespan;
    logic                  last_result;

    modport source (output valid, unit_index, start_time, finish_time, makespan,
                    last_result, input ready);
    modport sink (input valid, unit_index, start_time, finish_time, makespan,
                  last_result, output ready);
endinterface

interface efuld_cfg_if import efuld_pkg::*;;
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] units_in_use;

    modport source (output valid, units_in_use, input ready);
    modport sink (input valid, units_in_use, output ready);
endinterface

// File: sv/efuld_alu.sv
// Shared saturating adder and less-than comparator used by the ready, scan, pick, finish, span and prefix steps.
module efuld_alu import efuld_pkg::*;
(
    input  logic [TIME_W-1:0] a,
    input  logic [TIME_W-1:0] b,
    output alu_res_t          res
);

    logic [TIME_W:0] wide_sum;

    assign wide_sum = {1'b0, a} + {1'b0, b};
    assign res.sum = wide_sum[TIME_W] ? {TIME_W{1'b1}} : wide_sum[TIME_W-1:0];
    assign res.lt = (a < b);

endmodule

// File: sv/efuld_core.sv
// Sequencer, unit state and result register of the layer dispatch block.
module efuld_core import efuld_pkg::*;
#(
    parameter int MAX_UNITS = MAX_UNITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CFG_W-1:0] units_in_use,
    efuld_layer_if.sink      layer,
    efuld_result_if.source   result
);

    localparam int NW = $clog2(MAX_UNITS + 1);
    localparam int IW = (MAX_UNITS > 1) ? $clog2(MAX_UNITS) : 1;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READY  = 3'd1;
    localparam logic [2:0] ST_SCAN   = 3'd2;
    localparam logic [2:0] ST_PICK   = 3'd3;
    localparam logic [2:0] ST_FINISH = 3'd4;
    localparam logic [2:0] ST_SPAN   = 3'd5;
    localparam logic [2:0] ST_PREFIX = 3'd6;
    localparam logic [2:0] ST_WRITE  = 3'd7;

    logic [2:0]         state_reg, state_next;
    logic [TIME_W-1:0]  unit_finish_reg [MAX_UNITS];
    logic [TIME_W-1:0]  unit_finish_next [MAX_UNITS];
    logic [NW-1:0]      layers_seen_reg, layers_seen_next;
    logic [TIME_W-1:0]  host_prefix_sum_reg, host_prefix_sum_next;
    logic [FIELD_W-1:0] previous_transfer_reg, previous_transfer_next;
    logic [TIME_W-1:0]  largest_finish_reg, largest_finish_next;
    logic               out_valid_reg, out_valid_next;

    logic [NW-1:0]      n_reg, n_next;
    logic [NW-1:0]      scan_reg, scan_next;
    logic [IW-1:0]      best_idx_reg, best_idx_next;
    logic [TIME_W-1:0]  best_val_reg, best_val_next;
    logic [TIME_W-1:0]  ready_time_reg, ready_time_next;
    logic [TIME_W-1:0]  start_reg, start_next;
    logic [TIME_W-1:0]  finish_reg, finish_next;
    logic [TIME_W-1:0]  span_reg, span_next;
    logic [TIME_W-1:0]  prefix_reg, prefix_next;
    logic [FIELD_W-1:0] host_reg, host_next;
    logic [FIELD_W-1:0] xfer_reg, xfer_next;
    logic [FIELD_W-1:0] utime_reg, utime_next;
    logic               last_reg, last_next;
    logic               opening_reg, opening_next;

    logic [UNIT_OUT_W-1:0] out_unit_reg, out_unit_next;
    logic [TIME_W-1:0]     out_start_reg, out_start_next;
    logic [TIME_W-1:0]     out_finish_reg, out_finish_next;
    logic [TIME_W-1:0]     out_span_reg, out_span_next;
    logic                  out_last_reg, out_last_next;

    logic [NW-1:0]     n_act;
    logic [NW-1:0]     scan_inc;
    logic [TIME_W-1:0] scan_val;
    logic [TIME_W-1:0] alu_a;
    logic [TIME_W-1:0] alu_b;
    alu_res_t          alu_res;

    efuld_alu u_alu
    (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    // A unit count of zero acts as one, and one above the unit array acts as its size.
    always_comb
    begin
        if (units_in_use == '0)
        begin
            n_act = NW'(1);
        end
        else if (32'(units_in_use) > MAX_UNITS)
        begin
            n_act = NW'(MAX_UNITS);
        end
        else
        begin
            n_act = NW'(units_in_use);
        end
    end

    assign scan_inc = scan_reg + NW'(1);
    assign scan_val = unit_finish_reg[scan_reg[IW-1:0]];

    always_comb
    begin
        state_next = state_reg;
        unit_finish_next = unit_finish_reg;
        layers_seen_next = layers_seen_reg;
        host_prefix_sum_next = host_prefix_sum_reg;
        previous_transfer_next = previous_transfer_reg;
        largest_finish_next = largest_finish_reg;
        out_valid_next = out_valid_reg && !result.ready;
        n_next = n_reg;
        scan_next = scan_reg;
        best_idx_next = best_idx_reg;
        best_val_next = best_val_reg;
        ready_time_next = ready_time_reg;
        start_next = start_reg;
        finish_next = finish_reg;
        span_next = span_reg;
        prefix_next = prefix_reg;
        host_next = host_reg;
        xfer_next = xfer_reg;
        utime_next = utime_reg;
        last_next = last_reg;
        opening_next = opening_reg;
        out_unit_next = out_unit_reg;
        out_start_next = out_start_reg;
        out_finish_next = out_finish_reg;
        out_span_next = out_span_reg;
        out_last_next = out_last_reg;
        alu_a = '0;
        alu_b = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (layer.valid)
                begin
                    host_next = layer.host_time;
                    xfer_next = layer.transfer_time;
                    utime_next = layer.unit_time;
                    last_next = layer.last_layer;
                    n_next = n_act;
                    if (layers_seen_reg < n_act)
                    begin
                        opening_next = 1'b1;
                        best_idx_next = layers_seen_reg[IW-1:0];
                        start_next = '0;
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        opening_next = 1'b0;
                        state_next = ST_READY;
                    end
                end
            end
            ST_READY:
            begin
                alu_a = host_prefix_sum_reg;
                alu_b = TIME_W'(previous_transfer_reg);
                ready_time_next = alu_res.sum;
                best_idx_next = '0;
                best_val_next = unit_finish_reg[0];
                scan_next = NW'(1);
                state_next = (n_reg == NW'(1)) ? ST_PICK : ST_SCAN;
            end
            ST_SCAN:
            begin
                alu_a = scan_val;
                alu_b = best_val_reg;
                if (alu_res.lt)
                begin
                    best_idx_next = scan_reg[IW-1:0];
                    best_val_next = scan_val;
                end
                scan_next = scan_inc;
                if (scan_inc == n_reg)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:
            begin
                alu_a = best_val_reg;
                alu_b = ready_time_reg;
                start_next = alu_res.lt ? ready_time_reg : best_val_reg;
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                alu_a = start_reg;
                alu_b = TIME_W'(utime_reg);
                finish_next = alu_res.sum;
                state_next = ST_SPAN;
            end
            ST_SPAN:
            begin
                alu_a = largest_finish_reg;
                alu_b = finish_reg;
                span_next = alu_res.lt ? finish_reg : largest_finish_reg;
                state_next = ST_PREFIX;
            end
            ST_PREFIX:
            begin
                alu_a = host_prefix_sum_reg;
                alu_b = TIME_W'(host_reg);
                prefix_next = alu_res.sum;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    out_unit_next = UNIT_OUT_W'(best_idx_reg);
                    out_start_next = start_reg;
                    out_finish_next = finish_reg;
                    out_span_next = span_reg;
                    out_last_next = last_reg;
                    state_next = ST_IDLE;
                    if (last_reg)
                    begin
                        unit_finish_next = '{default: '0};
                        layers_seen_next = '0;
                        host_prefix_sum_next = '0;
                        previous_transfer_next = '0;
                        largest_finish_next = '0;
                    end
                    else
                    begin
                        unit_finish_next[best_idx_reg] = finish_reg;
                        host_prefix_sum_next = prefix_reg;
                        previous_transfer_next = xfer_reg;
                        largest_finish_next = span_reg;
                        if (opening_reg)
                        begin
                            layers_seen_next = layers_seen_reg + NW'(1);
                        end
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            unit_finish_reg <= '{default: '0};
            layers_seen_reg <= '0;
            host_prefix_sum_reg <= '0;
            previous_transfer_reg <= '0;
            largest_finish_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unit_finish_reg <= unit_finish_next;
            layers_seen_reg <= layers_seen_next;
            host_prefix_sum_reg <= host_prefix_sum_next;
            previous_transfer_reg <= previous_transfer_next;
            largest_finish_reg <= largest_finish_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        scan_reg <= scan_next;
        best_idx_reg <= best_idx_next;
        best_val_reg <= best_val_next;
        ready_time_reg <= ready_time_next;
        start_reg <= start_next;
        finish_reg <= finish_next;
        span_reg <= span_next;
        prefix_reg <= prefix_next;
        host_reg <= host_next;
        xfer_reg <= xfer_next;
        utime_reg <= utime_next;
        last_reg <= last_next;
        opening_reg <= opening_next;
        out_unit_reg <= out_unit_next;
        out_start_reg <= out_start_next;
        out_finish_reg <= out_finish_next;
        out_span_reg <= out_span_next;
        out_last_reg <= out_last_next;
    end

    assign layer.ready = (state_reg == ST_IDLE);
    assign result.valid = out_valid_reg;
    assign result.unit_index = out_unit_reg;
    assign result.start_time = out_start_reg;
    assign result.finish_time = out_finish_reg;
    assign result.makespan = out_span_reg;
    assign result.last_result = out_last_reg;

endmodule

// File: sv/earliest_free_unit_layer_dispatch.sv
// Top level of the layer dispatch block: unit count register and dispatch core.
//
// Each request on the layer channel carries one layer of a list: host time, transfer time,
// unit time and a flag for the final layer. The block answers every request with one result
// on the result channel: the unit chosen, the start and finish times and the makespan so far.
// The cfg channel writes the number of units in use; it is always ready and should only be
// written while no request is outstanding.
// The first layers of a list, one per unit in use, start at time zero and skip the scan.
// For every later layer, one
// shared adder and comparator first forms the ready time, then compares the finish times one
// unit per cycle, and then works out the start, finish, makespan and host-time sum in turn.
// The layer channel is ready only between requests, so a new layer is taken in the cycle
// after the previous result is loaded into the result register.
// A result waits in that register while the receiver stalls, and a following layer may be
// accepted and worked on meanwhile; it is held back only at its final step.
// Reset clears all finish times and sums and sets the unit count to eight; the final layer
// of a list clears them again but leaves the unit count alone.
module earliest_free_unit_layer_dispatch import efuld_pkg::*;
#(
    parameter int MAX_UNITS = MAX_UNITS_DEF
)
(
    input  logic           clk,
    input  logic           rst_n,
    efuld_cfg_if.sink      cfg,
    efuld_layer_if.sink    layer,
    efuld_result_if.source result
);

    logic [CFG_W-1:0] units_in_use_reg, units_in_use_next;

    assign cfg.ready = 1'b1;
    assign units_in_use_next = cfg.valid ? cfg.units_in_use : units_in_use_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            units_in_use_reg <= UNITS_RESET;
        end
        else
        begin
            units_in_use_reg <= units_in_use_next;
        end
    end

    efuld_core #(
        .MAX_UNITS (MAX_UNITS)
    ) u_core
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .units_in_use (units_in_use_reg),
        .layer        (layer),
        .result       (result)
    );

endmodule

// File: sv/efuld_checker.sv
// Port-level assertions for the layer dispatch block and their binding to the top level.
`include "earliest_free_unit_layer_dispatch_defines.svh"

module efuld_checker import efuld_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              layer_valid,
    input logic              layer_ready,
    input logic              result_valid,
    input logic              result_ready,
    input logic [TIME_W-1:0] start_time,
    input logic [TIME_W-1:0] finish_time,
    input logic [TIME_W-1:0] makespan
);

    `EFULD_ASSERT_NEXT(busy_after_request, layer_valid && layer_ready, !layer_ready,
        "layer channel still ready after a request was taken")

    `EFULD_ASSERT_NEXT(result_held, result_valid && !result_ready,
        result_valid && $stable(finish_time), "stalled result changed or vanished")

    `EFULD_ASSERT_SAME(finish_after_start, result_valid, finish_time >= start_time,
        "finish time lies before start time")

    `EFULD_ASSERT_SAME(makespan_covers_finish, result_valid, makespan >= finish_time,
        "makespan is below the finish time of the layer")

endmodule

bind earliest_free_unit_layer_dispatch efuld_checker u_efuld_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .layer_valid  (layer.valid),
    .layer_ready  (layer.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .start_time   (result.start_time),
    .finish_time  (result.finish_time),
    .makespan     (result.makespan)
);

// File: tb/earliest_free_unit_layer_dispatch_test.sv
// Self-checking test of the layer dispatch block, with a scoreboard that predicts every result.
module earliest_free_unit_layer_dispatch_test;
    import efuld_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned LONG_HOLD = 400;
    localparam logic [FIELD_W-1:0] FIELD_MAX = '1;

    typedef struct packed {
        logic [UNIT_OUT_W-1:0] unit_index;
        logic [TIME_W-1:0]     start_time;
        logic [TIME_W-1:0]     finish_time;
        logic [TIME_W-1:0]     makespan;
        logic                  last_result;
    } dispatch_result_t;

    class dispatch_scoreboard;
        logic [CFG_W-1:0]  unit_count;
        logic [TIME_W-1:0] unit_finish [MAX_UNITS_DEF];
        int unsigned       opening_layers;
        logic [TIME_W-1:0] host_sum;
        logic [FIELD_W-1:0] prev_transfer;
        logic [TIME_W-1:0] largest_finish;
        dispatch_result_t  expected_dispatch_q [$];
        int unsigned       mismatch_count;

        function new();
            unit_count = UNITS_RESET;
            mismatch_count = 0;
            clear_list();
        endfunction

        function void clear_list();
            foreach (unit_finish[i])
                unit_finish[i] = '0;
            opening_layers = 0;
            host_sum = '0;
            prev_transfer = '0;
            largest_finish = '0;
        endfunction

        function logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                            input logic [TIME_W-1:0] b);
            logic [TIME_W:0] s;
            s = {1'b0, a} + {1'b0, b};
            return s[TIME_W] ? '1 : s[TIME_W-1:0];
        endfunction

        function int unsigned pending();
            return expected_dispatch_q.size();
        endfunction

        function void note_layer(input logic [FIELD_W-1:0] host, input logic [FIELD_W-1:0] xfer,
                                 input logic [FIELD_W-1:0] utime, input logic last);
            dispatch_result_t  want;
            int unsigned       n;
            int unsigned       pick;
            logic [TIME_W-1:0] ready_at;
            logic [TIME_W-1:0] start;
            logic [TIME_W-1:0] finish;
            if (unit_count == 0)
                n = 1;
            else if (unit_count > MAX_UNITS_DEF)
                n = MAX_UNITS_DEF;
            else
                n = unit_count;
            if (opening_layers < n)
            begin
                pick = opening_layers;
                start = '0;
                opening_layers++;
            end
            else
            begin
                ready_at = sat_add(host_sum, {{(TIME_W-FIELD_W){1'b0}}, prev_transfer});
                pick = 0;
                for (int unsigned i = 1; i < n; i++)
                begin
                    if (unit_finish[i] < unit_finish[pick])
                        pick = i;
                end
                start = (ready_at > unit_finish[pick]) ? ready_at : unit_finish[pick];
            end
            finish = sat_add(start, {{(TIME_W-FIELD_W){1'b0}}, utime});
            unit_finish[pick] = finish;
            if (finish > largest_finish)
                largest_finish = finish;
            want.unit_index = UNIT_OUT_W'(pick);
            want.start_time = start;
            want.finish_time = finish;
            want.makespan = largest_finish;
            want.last_result = last;
            expected_dispatch_q.push_back(want);
            host_sum = sat_add(host_sum, {{(TIME_W-FIELD_W){1'b0}}, host});
            prev_transfer = xfer;
            if (last)
                clear_list();
        endfunction

        function void check_dispatch(input dispatch_result_t got);
            dispatch_result_t want;
            if (expected_dispatch_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Result with no request outstanding: unit %0d start %0d",
                             got.unit_index, got.start_time,
                             " finish %0d makespan %0d last %0d",
                             got.finish_time, got.makespan, got.last_result);
                return;
            end
            want = expected_dispatch_q.pop_front();
            if (got.unit_index !== want.unit_index || got.start_time !== want.start_time ||
                got.finish_time !== want.finish_time || got.makespan !== want.makespan ||
                got.last_result !== want.last_result)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                begin
                    $display("Mismatch, expected: unit %0d start %0d finish %0d",
                             want.unit_index, want.start_time, want.finish_time,
                             " makespan %0d last %0d", want.makespan, want.last_result);
                    $display("          actual:   unit %0d start %0d finish %0d",
                             got.unit_index, got.start_time, got.finish_time,
                             " makespan %0d last %0d", got.makespan, got.last_result);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    efuld_cfg_if    cfg_bus ();
    efuld_layer_if  layer_bus ();
    efuld_result_if result_bus ();

    dispatch_scoreboard sb;
    bit                 tx_gaps;
    bit                 rx_gaps;
    int unsigned        long_hold;
    int unsigned        list_left;
    int unsigned        cycle_count;

    earliest_free_unit_layer_dispatch dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_bus),
        .layer  (layer_bus),
        .result (result_bus)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    function automatic logic [FIELD_W-1:0] draw_field();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FIELD_MAX;
            2: return FIELD_W'($urandom_range(0, 255));
            default: return FIELD_W'($urandom_range(0, 65535));
        endcase
    endfunction

    task automatic send_layer(input logic [FIELD_W-1:0] host, input logic [FIELD_W-1:0] xfer,
                              input logic [FIELD_W-1:0] utime, input logic last);
        int unsigned gap;
        gap = tx_gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0)
        begin
            layer_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        layer_bus.valid <= 1'b1;
        layer_bus.host_time <= host;
        layer_bus.transfer_time <= xfer;
        layer_bus.unit_time <= utime;
        layer_bus.last_layer <= last;
        do
            @(posedge clk);
        while (layer_bus.ready !== 1'b1);
        sb.note_layer(host, xfer, utime, last);
    endtask

    // The sender stops offering requests and waits until every result has come back.
    task automatic await_all_results();
        layer_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_unit_count(input logic [CFG_W-1:0] count);
        await_all_results();
        cfg_bus.valid <= 1'b1;
        cfg_bus.units_in_use <= count;
        do
            @(posedge clk);
        while (cfg_bus.ready !== 1'b1);
        sb.unit_count = count;
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic send_random_layers(input int unsigned count, input bit pause_midway);
        logic last;
        for (int unsigned k = 0; k < count; k++)
        begin
            if (pause_midway && k == count / 2)
                await_all_results();
            if (list_left == 0)
                list_left = $urandom_range(1, 20);
            last = (list_left == 1);
            list_left--;
            if ($urandom_range(0, 11) == 0)
                last = 1'($urandom_range(0, 1));
            send_layer(draw_field(), draw_field(), draw_field(), last);
        end
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        dispatch_result_t got;
        result_bus.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_gaps ? $urandom_range(0, 15) : 0;
            if (long_hold != 0)
            begin
                stall = long_hold;
                long_hold = 0;
            end
            if (stall != 0)
            begin
                result_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            result_bus.ready <= 1'b1;
            do
                @(posedge clk);
            while (result_bus.valid !== 1'b1);
            got.unit_index = result_bus.unit_index;
            got.start_time = result_bus.start_time;
            got.finish_time = result_bus.finish_time;
            got.makespan = result_bus.makespan;
            got.last_result = result_bus.last_result;
            sb.check_dispatch(got);
        end
    end

    initial
    begin : stimulus
        logic [CFG_W-1:0] opening_counts [4];
        sb = new();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        long_hold = 0;
        list_left = 0;
        opening_counts = '{4'd1, 4'd8, 4'd15, 4'd0};
        rst_n = 1'b0;
        cfg_bus.valid = 1'b0;
        cfg_bus.units_in_use = UNITS_RESET;
        layer_bus.valid = 1'b0;
        layer_bus.host_time = '0;
        layer_bus.transfer_time = '0;
        layer_bus.unit_time = '0;
        layer_bus.last_layer = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // A list shorter than the unit count, with the field extremes.
        send_layer('0, '0, '0, 1'b0);
        send_layer(FIELD_MAX, FIELD_MAX, FIELD_MAX, 1'b0);
        send_layer(16'd1, 16'd2, 16'd3, 1'b1);

        // A unit count of zero behaves as a single unit.
        write_unit_count(4'd0);
        send_layer(FIELD_MAX, FIELD_MAX, FIELD_MAX, 1'b0);
        send_layer(FIELD_MAX, '0, FIELD_MAX, 1'b0);
        send_layer('0, FIELD_MAX, '0, 1'b0);
        send_layer(16'd100, 16'd200, 16'd300, 1'b1);

        // A unit count above the number of units is clamped.
        write_unit_count(4'd15);
        for (int k = 0; k < 10; k++)
            send_layer(16'(k * 7), 16'(k * 13), 16'(1000 - k * 90), k == 9);

        // The unit count changes in the middle of a list.
        write_unit_count(4'd3);
        for (int k = 0; k < 4; k++)
            send_layer(16'(k + 5), 16'(k * 3), 16'(50 * (k + 1)), 1'b0);
        write_unit_count(4'd6);
        for (int k = 0; k < 4; k++)
            send_layer(16'(k + 9), 16'(k * 11), 16'(40 * (k + 2)), k == 3);

        for (int phase = 0; phase < 14; phase++)
        begin
            write_unit_count(phase < 4 ? opening_counts[phase] : CFG_W'($urandom_range(0, 15)));
            case ($urandom_range(0, 3))
                0: begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
                1: begin tx_gaps = 1'b1; rx_gaps = 1'b0; end
                2: begin tx_gaps = 1'b0; rx_gaps = 1'b1; end
                default: begin tx_gaps = 1'b1; rx_gaps = 1'b1; end
            endcase
            if (phase == 2)
            begin
                tx_gaps = 1'b0;
                long_hold = LONG_HOLD;
            end
            send_random_layers(50, phase == 5);
        end

        await_all_results();
        repeat (20) @(posedge clk);
        if (sb.mismatch_count == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
